// File: rtl/core/gddarc_pkg.sv
// Shared types and constants for the grid ray caster.
`default_nettype none
package gddarc_pkg;
   localparam logic [1:0] CSR_RENDER_DISTANCE = 2'd0;
   localparam logic [1:0] CSR_MAP_WIDTH = 2'd1;
   localparam logic [1:0] CSR_MAP_HEIGHT = 2'd2;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_CAST = 1'b1;

   typedef struct packed {
      logic               action;
      logic [5:0]         cell_col;
      logic [5:0]         cell_row;
      logic [3:0]         cell_kind;
      logic [15:0]        origin_x;
      logic [15:0]        origin_y;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
   } req_type;

   typedef struct packed {
      logic [15:0] travel_len;
      logic        wall_hit;
      logic        corner_block;
      logic [7:0]  hit_col;
      logic [7:0]  hit_row;
      logic [3:0]  hit_kind;
   } rsp_type;

   typedef enum logic [12:0] {
      ST_CLEAR = 13'b0000000000001,
      ST_IDLE  = 13'b0000000000010,
      ST_DIVX  = 13'b0000000000100,
      ST_DIVY  = 13'b0000000001000,
      ST_MUL   = 13'b0000000010000,
      ST_MARCH = 13'b0000000100000,
      ST_RDC   = 13'b0000001000000,
      ST_CHKC  = 13'b0000010000000,
      ST_RDS1  = 13'b0000100000000,
      ST_CHKS1 = 13'b0001000000000,
      ST_RDS2  = 13'b0010000000000,
      ST_CHKS2 = 13'b0100000000000,
      ST_DONE  = 13'b1000000000000
   } state_type;
endpackage
`default_nettype wire

// File: rtl/core/grid_dda_ray_caster_unit.sv
// Top level of the grid ray caster: map memory, reciprocal divider and DDA walk.
//
//  channel | dir | ports                         | transfer when
//  req     | in  | req_valid req_stall req_payload | valid && !stall
//  rsp     | out | rsp_valid rsp_stall rsp_payload | valid && !stall
//  csr     | in  | csr_we csr_index csr_wdata      | csr_we
//
// A write item goes to the map memory as it is taken. A cast runs the two bit-serial
// reciprocal divisions, then the side products, then the grid steps, each paced
// by the single read port of the map memory (one cell per read).
// After reset a clearing pass zeroes the map, one cell a cycle;
// no item is taken until it ends.
// A stalled result holds only the finish of the next cast.
`default_nettype none
module grid_dda_ray_caster_unit #(
   parameter int unsigned MAP_SIDE = 64,
   parameter int unsigned WALL_KINDS = 15
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire gddarc_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output gddarc_pkg::rsp_type  rsp_payload,
   input  wire                  csr_we,
   input  wire [1:0]            csr_index,
   input  wire [15:0]           csr_wdata
);
   localparam int unsigned DEPTH = MAP_SIDE * MAP_SIDE;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam logic [8:0] SIDE9 = 9'(MAP_SIDE);
   localparam logic [3:0] KIND_MAX = 4'(WALL_KINDS);

   gddarc_pkg::state_type state_ff, state_in;

   logic [15:0] render_ff;
   logic [6:0]  width_ff, height_ff;

   logic [3:0] mem [DEPTH];
   logic [3:0] mem_q_ff;
   logic [ADDR_W-1:0] rd_addr, wr_addr, clr_ff;
   logic [3:0] wr_data;
   logic wr_en;

   logic [15:0] magx_ff, magy_ff;
   logic negx_ff, negy_ff, infx_ff, infy_ff;
   logic [7:0] fracx_ff, fracy_ff;
   logic [4:0] cnt_ff;
   logic [16:0] rem_ff;
   logic [30:0] quo_ff;
   logic [30:0] pcx_ff, pcy_ff;
   logic [31:0] sx_ff, sy_ff, len_ff;
   logic [7:0] cx_ff, cy_ff, pcol_ff, prow_ff;
   logic tie_ff, nomarch_ff;
   logic rsp_valid_ff;
   gddarc_pkg::rsp_type rsp_ff;

   logic accept, rsp_done;
   assign accept = req_valid && !req_stall;
   assign rsp_done = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != gddarc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   function automatic logic in_map(input logic [7:0] c, input logic [7:0] r,
                                   input logic [6:0] w, input logic [6:0] h);
      in_map = ({1'b0, c} < {2'b0, w}) && ({1'b0, r} < {2'b0, h})
               && ({1'b0, c} < SIDE9) && ({1'b0, r} < SIDE9);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [7:0] c,
                                                   input logic [7:0] r);
      logic [ADDR_W+8:0] a;
      a = (ADDR_W+9)'(r) * (ADDR_W+9)'(MAP_SIDE) + (ADDR_W+9)'(c);
      cell_addr = a[ADDR_W-1:0];
   endfunction

   // divider step
   logic [16:0] rem_sh;
   logic [15:0] div_mag;
   logic div_ge;
   logic [16:0] rem_nx;
   logic [30:0] quo_nx;
   always_comb begin
      div_mag = state_ff == gddarc_pkg::ST_DIVX ? magx_ff : magy_ff;
      rem_sh = {rem_ff[15:0], cnt_ff == 5'd30};
      div_ge = rem_sh >= {1'b0, div_mag};
      rem_nx = div_ge ? rem_sh - {1'b0, div_mag} : rem_sh;
      quo_nx = {quo_ff[29:0], div_ge};
   end

   // walk step
   logic [23:0] limit;
   logic choose_x, choose_y, tie;
   logic cont;
   logic [31:0] len_clip;
   assign limit = {render_ff, 8'd0};
   always_comb begin
      choose_x = !infx_ff && (infy_ff || sx_ff <= sy_ff);
      choose_y = !infy_ff && (infx_ff || sy_ff <= sx_ff);
      tie = choose_x && choose_y;
      cont = len_ff <= {8'd0, limit};
      len_clip = cont ? len_ff : {8'd0, limit};
   end

   // distance to the first grid line: fraction left in the start cell
   logic [8:0] factx, facty;
   logic [39:0] prodx, prody;
   always_comb begin
      factx = negx_ff ? {1'b0, fracx_ff} : 9'd256 - {1'b0, fracx_ff};
      facty = negy_ff ? {1'b0, fracy_ff} : 9'd256 - {1'b0, fracy_ff};
      prodx = 40'(pcx_ff) * 40'(factx);
      prody = 40'(pcy_ff) * 40'(facty);
   end

   always_comb begin
      rd_addr = cell_addr(cx_ff, cy_ff);
      case (state_ff)
         gddarc_pkg::ST_RDS1: rd_addr = cell_addr(pcol_ff, cy_ff);
         gddarc_pkg::ST_RDS2: rd_addr = cell_addr(cx_ff, prow_ff);
         default: rd_addr = cell_addr(cx_ff, cy_ff);
      endcase
      wr_en = 1'b0;
      wr_addr = clr_ff;
      wr_data = 4'd0;
      if (state_ff == gddarc_pkg::ST_CLEAR) begin
         wr_en = 1'b1;
      end else if (accept && req_payload.action == gddarc_pkg::ACT_WRITE
                   && {2'b0, req_payload.cell_col} < SIDE9
                   && {2'b0, req_payload.cell_row} < SIDE9) begin
         wr_en = 1'b1;
         wr_addr = cell_addr({2'b0, req_payload.cell_col}, {2'b0, req_payload.cell_row});
         wr_data = req_payload.cell_kind > KIND_MAX ? KIND_MAX : req_payload.cell_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      mem_q_ff <= mem[rd_addr];
   end

   logic c_in, s1_in, s2_in;
   assign c_in = in_map(cx_ff, cy_ff, width_ff, height_ff);
   assign s1_in = in_map(pcol_ff, cy_ff, width_ff, height_ff);
   assign s2_in = in_map(cx_ff, prow_ff, width_ff, height_ff);

   logic finish;
   logic fin_hit, fin_corner;
   logic [3:0] fin_kind;
   always_comb begin
      state_in = state_ff;
      finish = 1'b0;
      fin_hit = 1'b0;
      fin_corner = 1'b0;
      fin_kind = 4'd0;
      case (state_ff)
         gddarc_pkg::ST_CLEAR:
            if (clr_ff == ADDR_W'(DEPTH - 1)) state_in = gddarc_pkg::ST_IDLE;
         gddarc_pkg::ST_IDLE:
            if (accept && req_payload.action == gddarc_pkg::ACT_CAST)
               state_in = gddarc_pkg::ST_DIVX;
         gddarc_pkg::ST_DIVX:
            if (cnt_ff == 5'd0) state_in = gddarc_pkg::ST_DIVY;
         gddarc_pkg::ST_DIVY:
            if (cnt_ff == 5'd0) state_in = gddarc_pkg::ST_MUL;
         gddarc_pkg::ST_MUL:
            state_in = (infx_ff && infy_ff) ? gddarc_pkg::ST_RDC : gddarc_pkg::ST_MARCH;
         gddarc_pkg::ST_MARCH: state_in = gddarc_pkg::ST_RDC;
         gddarc_pkg::ST_RDC: state_in = gddarc_pkg::ST_CHKC;
         gddarc_pkg::ST_CHKC:
            if (nomarch_ff) begin
               finish = 1'b1;
               fin_kind = c_in ? mem_q_ff : 4'd0;
            end else if (c_in && mem_q_ff != 4'd0) begin
               finish = 1'b1;
               fin_hit = 1'b1;
               fin_kind = mem_q_ff;
            end else if (c_in && tie_ff) begin
               state_in = gddarc_pkg::ST_RDS1;
            end else if (cont) begin
               state_in = gddarc_pkg::ST_MARCH;
            end else begin
               finish = 1'b1;
            end
         gddarc_pkg::ST_RDS1: state_in = gddarc_pkg::ST_CHKS1;
         gddarc_pkg::ST_CHKS1:
            if (s1_in && mem_q_ff != 4'd0) state_in = gddarc_pkg::ST_RDS2;
            else if (cont) state_in = gddarc_pkg::ST_MARCH;
            else finish = 1'b1;
         gddarc_pkg::ST_RDS2: state_in = gddarc_pkg::ST_CHKS2;
         gddarc_pkg::ST_CHKS2:
            if (s2_in && mem_q_ff != 4'd0) begin
               finish = 1'b1;
               fin_hit = 1'b1;
               fin_corner = 1'b1;
            end else if (cont) begin
               state_in = gddarc_pkg::ST_MARCH;
            end else begin
               finish = 1'b1;
            end
         gddarc_pkg::ST_DONE: ;
         default: state_in = gddarc_pkg::ST_IDLE;
      endcase
      // hold the finished result until the output register is free
      if (finish || state_ff == gddarc_pkg::ST_DONE)
         state_in = (rsp_valid_ff && rsp_stall) ? gddarc_pkg::ST_DONE : gddarc_pkg::ST_IDLE;
   end

   logic [3:0] hold_kind_ff;
   logic hold_hit_ff, hold_corner_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gddarc_pkg::ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         render_ff <= 16'd4096;
         width_ff <= 7'd64;
         height_ff <= 7'd64;
      end else begin
         state_ff <= state_in;
         if (state_ff == gddarc_pkg::ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (csr_we) begin
            case (csr_index)
               gddarc_pkg::CSR_RENDER_DISTANCE: render_ff <= csr_wdata;
               gddarc_pkg::CSR_MAP_WIDTH: width_ff <= csr_wdata[6:0];
               gddarc_pkg::CSR_MAP_HEIGHT: height_ff <= csr_wdata[6:0];
               default: ;
            endcase
         end
         if (state_in == gddarc_pkg::ST_IDLE && state_ff != gddarc_pkg::ST_IDLE
             && state_ff != gddarc_pkg::ST_CLEAR)
            rsp_valid_ff <= 1'b1;
         else if (rsp_done)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         magx_ff <= req_payload.dir_x[15] ? 16'(-req_payload.dir_x) : req_payload.dir_x;
         magy_ff <= req_payload.dir_y[15] ? 16'(-req_payload.dir_y) : req_payload.dir_y;
         negx_ff <= req_payload.dir_x[15];
         negy_ff <= req_payload.dir_y[15];
         infx_ff <= req_payload.dir_x == 16'sd0;
         infy_ff <= req_payload.dir_y == 16'sd0;
         fracx_ff <= req_payload.origin_x[7:0];
         fracy_ff <= req_payload.origin_y[7:0];
         cx_ff <= req_payload.origin_x[15:8];
         cy_ff <= req_payload.origin_y[15:8];
         cnt_ff <= 5'd30;
         rem_ff <= '0;
         quo_ff <= '0;
         len_ff <= '0;
      end
      case (state_ff)
         gddarc_pkg::ST_DIVX, gddarc_pkg::ST_DIVY: begin
            if (cnt_ff == 5'd0) begin
               cnt_ff <= 5'd30;
               rem_ff <= '0;
               quo_ff <= '0;
               if (state_ff == gddarc_pkg::ST_DIVX) pcx_ff <= quo_nx;
               else pcy_ff <= quo_nx;
            end else begin
               rem_ff <= rem_nx;
               quo_ff <= quo_nx;
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
         gddarc_pkg::ST_MUL: begin
            sx_ff <= prodx[39:8];
            sy_ff <= prody[39:8];
            nomarch_ff <= infx_ff && infy_ff;
            if (infx_ff && infy_ff) len_ff <= {8'd0, limit};
         end
         gddarc_pkg::ST_MARCH: begin
            tie_ff <= tie;
            pcol_ff <= cx_ff;
            prow_ff <= cy_ff;
            len_ff <= choose_x ? sx_ff : sy_ff;
            if (choose_x) begin
               sx_ff <= sx_ff + {1'b0, pcx_ff};
               cx_ff <= negx_ff ? cx_ff - 1'b1 : cx_ff + 1'b1;
            end
            if (choose_y) begin
               sy_ff <= sy_ff + {1'b0, pcy_ff};
               cy_ff <= negy_ff ? cy_ff - 1'b1 : cy_ff + 1'b1;
            end
         end
         default: ;
      endcase
      if (finish) begin
         hold_kind_ff <= fin_kind;
         hold_hit_ff <= fin_hit;
         hold_corner_ff <= fin_corner;
      end
      if (finish && !(rsp_valid_ff && rsp_stall)) begin
         rsp_ff.travel_len <= len_clip[23:8];
         rsp_ff.wall_hit <= fin_hit;
         rsp_ff.corner_block <= fin_corner;
         rsp_ff.hit_col <= cx_ff;
         rsp_ff.hit_row <= cy_ff;
         rsp_ff.hit_kind <= fin_kind;
      end else if (state_ff == gddarc_pkg::ST_DONE && !(rsp_valid_ff && rsp_stall)) begin
         rsp_ff.travel_len <= len_clip[23:8];
         rsp_ff.wall_hit <= hold_hit_ff;
         rsp_ff.corner_block <= hold_corner_ff;
         rsp_ff.hit_col <= cx_ff;
         rsp_ff.hit_row <= cy_ff;
         rsp_ff.hit_kind <= hold_kind_ff;
      end
   end

`ifndef ASSERT_OFF
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      accept |-> $past(state_in) == gddarc_pkg::ST_IDLE || $past(reset))
      else $error("item taken while busy");
   a_corner_is_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.corner_block |-> rsp_ff.wall_hit && rsp_ff.hit_kind == 4'd0)
      else $error("corner result without hit");
   a_len_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && $rose(rsp_valid_ff) |-> rsp_ff.travel_len <= render_ff)
      else $error("length beyond render distance");
   a_no_map_write_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en && state_ff != gddarc_pkg::ST_CLEAR |-> state_ff == gddarc_pkg::ST_IDLE)
      else $error("map write while walking");
`endif
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the grid ray caster: directed and random map writes and ray casts.
`timescale 1ns / 1ps
module tb_top;
   localparam int SIDE = 64;
   localparam int STALL_LIMIT = 60000;
   localparam logic [1:0] CSR_SPARE = 2'd3;

   logic clock, reset;
   logic req_valid, req_stall;
   gddarc_pkg::req_type req_payload;
   logic rsp_valid, rsp_stall;
   gddarc_pkg::rsp_type rsp_payload;
   logic csr_we;
   logic [1:0] csr_index;
   logic [15:0] csr_wdata;

   grid_dda_ray_caster_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // predictor state
   logic [3:0] wall_map [SIDE*SIDE];
   logic [15:0] render_dist;
   logic [6:0] map_w, map_h;

   gddarc_pkg::req_type item_q[$];
   gddarc_pkg::rsp_type hit_q[$];
   int send_idle, recv_stall;
   int errors;
   int quiet_cycles;

   function automatic bit in_map(logic [7:0] c, logic [7:0] r);
      return c < map_w && r < map_h && c < SIDE && r < SIDE;
   endfunction

   function automatic logic [3:0] kind_at(logic [7:0] c, logic [7:0] r);
      if (!in_map(c, r)) return 4'd0;
      return wall_map[{r[5:0], c[5:0]}];
   endfunction

   function automatic void axis_init(input logic [15:0] d, input logic [15:0] pos,
                                     output logic [7:0] stp, output logic [63:0] per,
                                     output logic [63:0] side);
      logic [15:0] mag;
      logic [63:0] frac;
      frac = 64'(pos[7:0]);
      if (d == 16'd0) begin
         stp = 8'd0;
         per = '1;
         side = '1;
      end else begin
         mag = d[15] ? 16'(17'h10000 - 17'(d)) : d;
         per = (64'd1 << 30) / 64'(mag);
         if (d[15]) begin
            stp = 8'hFF;
            side = (per * frac) >> 8;
         end else begin
            stp = 8'd1;
            side = (per * (64'd256 - frac)) >> 8;
         end
      end
   endfunction

   function automatic gddarc_pkg::rsp_type trace_ray(gddarc_pkg::req_type it);
      logic [7:0] cx, cy, stx, sty;
      logic [63:0] dx, dy, sx, sy, len, limit;
      bit hit, corner, tie;
      gddarc_pkg::rsp_type r;
      hit = 1'b0;
      corner = 1'b0;
      cx = it.origin_x[15:8];
      cy = it.origin_y[15:8];
      axis_init(it.dir_x, it.origin_x, stx, dx, sx);
      axis_init(it.dir_y, it.origin_y, sty, dy, sy);
      limit = 64'(render_dist) << 8;
      len = '0;
      if (sx == '1 && sy == '1) begin
         len = limit;
      end else begin
         while (len <= limit) begin
            tie = 1'b0;
            if (sx < sy) begin
               len = sx; sx += dx; cx += stx;
            end else if (sx > sy) begin
               len = sy; sy += dy; cy += sty;
            end else begin
               tie = 1'b1; len = sx; sx += dx; sy += dy; cx += stx; cy += sty;
            end
            if (in_map(cx, cy)) begin
               if (kind_at(cx, cy) != 0) begin
                  hit = 1'b1;
                  break;
               end
               if (tie && kind_at(cx - stx, cy) != 0 && kind_at(cx, cy - sty) != 0) begin
                  hit = 1'b1;
                  corner = 1'b1;
                  break;
               end
            end
         end
      end
      if (len > limit) len = limit;
      r.travel_len = len[23:8];
      r.wall_hit = hit;
      r.corner_block = corner;
      r.hit_col = cx;
      r.hit_row = cy;
      r.hit_kind = kind_at(cx, cy);
      return r;
   endfunction

   function automatic void apply_item(gddarc_pkg::req_type it);
      if (it.action == gddarc_pkg::ACT_WRITE)
         wall_map[{it.cell_row, it.cell_col}] = it.cell_kind;
      else
         hit_q.push_back(trace_ray(it));
   endfunction

   // driver: hold a stalled transfer, otherwise launch the next item or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) apply_item(req_payload);
         if (!req_valid || !req_stall) begin
            if (item_q.size() > 0 && $urandom_range(99) >= send_idle) begin
               req_valid <= 1'b1;
               req_payload <= item_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      gddarc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hit_q.size() == 0) begin
            $display("%0t unexpected result %p", $time, rsp_payload);
            errors++;
         end else begin
            want = hit_q.pop_front();
            check_field("travel_len", want.travel_len, rsp_payload.travel_len);
            check_field("wall_hit", want.wall_hit, rsp_payload.wall_hit);
            check_field("corner_block", want.corner_block, rsp_payload.corner_block);
            check_field("hit_col", want.hit_col, rsp_payload.hit_col);
            check_field("hit_row", want.hit_row, rsp_payload.hit_row);
            check_field("hit_kind", want.hit_kind, rsp_payload.hit_kind);
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall);
   end

   // watchdog: count cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == gddarc_pkg::CSR_RENDER_DISTANCE) render_dist = val;
      else if (idx == gddarc_pkg::CSR_MAP_WIDTH) map_w = val[6:0];
      else if (idx == gddarc_pkg::CSR_MAP_HEIGHT) map_h = val[6:0];
      @(negedge clock);
   endtask

   task automatic drain;
      @(negedge clock);
      wait (item_q.size() == 0 && !req_valid && hit_q.size() == 0);
      repeat (20) @(negedge clock);
   endtask

   function automatic gddarc_pkg::req_type wall_item(int c, int r, int k);
      gddarc_pkg::req_type it;
      it = '0;
      it.action = gddarc_pkg::ACT_WRITE;
      it.cell_col = 6'(c);
      it.cell_row = 6'(r);
      it.cell_kind = 4'(k);
      return it;
   endfunction

   function automatic gddarc_pkg::req_type cast_item(int ox, int oy, int dx, int dy);
      gddarc_pkg::req_type it;
      it = '0;
      it.action = gddarc_pkg::ACT_CAST;
      it.origin_x = 16'(ox);
      it.origin_y = 16'(oy);
      it.dir_x = 16'(dx);
      it.dir_y = 16'(dy);
      return it;
   endfunction

   function automatic gddarc_pkg::req_type random_item(bit far_origin);
      gddarc_pkg::req_type it;
      logic [95:0] raw;
      int dx, dy, pick;
      real mag;
      raw = {$urandom, $urandom, $urandom};
      it = raw[$bits(gddarc_pkg::req_type)-1:0];
      if ($urandom_range(99) < 30) begin
         it.action = gddarc_pkg::ACT_WRITE;
         // keep walls sparse so rays travel
         if ($urandom_range(1)) it.cell_kind = 4'd0;
         return it;
      end
      it.action = gddarc_pkg::ACT_CAST;
      if (!far_origin) begin
         it.origin_x = 16'($urandom_range(16'h3FFF));
         it.origin_y = 16'($urandom_range(16'h3FFF));
      end
      pick = $urandom_range(9);
      if (pick < 6) begin
         dx = int'($urandom_range(32768)) - 16384;
         mag = $sqrt(268435456.0 - real'(dx) * real'(dx));
         dy = $urandom_range(1) ? int'(mag) : -int'(mag);
      end else if (pick < 8) begin
         // exact diagonal with matching fractions: forces ties when both signs agree
         dx = $urandom_range(1) ? 11585 : -11585;
         dy = $urandom_range(1) ? 11585 : -11585;
         it.origin_y[7:0] = it.origin_x[7:0];
      end else if (pick == 8) begin
         dx = $urandom_range(1) ? 0 : 16384;
         dy = $urandom_range(1) ? 0 : -16384;
      end else begin
         dx = $urandom_range(16'hFFFF);
         dy = $urandom_range(16'hFFFF);
      end
      it.dir_x = 16'(dx);
      it.dir_y = 16'(dy);
      return it;
   endfunction

   task automatic random_phase(int count, int s_idle, int r_stall, bit far_origin);
      send_idle = s_idle;
      recv_stall = r_stall;
      for (int i = 0; i < count; i++) item_q.push_back(random_item(far_origin));
      drain();
   endtask

   initial begin
      clock = 0;
      reset = 1;
      req_valid = 0;
      req_payload = '0;
      rsp_stall = 0;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      errors = 0;
      send_idle = 0;
      recv_stall = 0;
      render_dist = 16'd4096;
      map_w = 7'd64;
      map_h = 7'd64;
      foreach (wall_map[i]) wall_map[i] = 4'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at reset settings
      item_q.push_back(wall_item(63, 63, 15));
      item_q.push_back(wall_item(0, 0, 9));
      item_q.push_back(wall_item(10, 5, 15));
      item_q.push_back(cast_item(0, 0, 0, 0));
      item_q.push_back(cast_item(16'h0180, 16'h0580, 16384, 0));
      item_q.push_back(cast_item(16'h0A80, 16'h0580, -32768, 0));
      item_q.push_back(cast_item(16'h0280, 16'h0280, 0, 1));
      item_q.push_back(cast_item(16'hFFFF, 16'hFFFF, -16384, -16384));
      item_q.push_back(cast_item(16'h3E40, 16'h3E40, 11585, 11585));
      item_q.push_back(wall_item(9, 8, 3));
      item_q.push_back(wall_item(8, 9, 4));
      item_q.push_back(cast_item(16'h0880, 16'h0880, 11585, 11585));
      item_q.push_back(cast_item(16'h0A80, 16'h0A80, -11585, -11585));
      item_q.push_back(cast_item(16'h0500, 16'h0F00, 0, -16384));
      item_q.push_back(cast_item(16'h0000, 16'h0000, 32767, 16'h8000));
      item_q.push_back(wall_item(63, 63, 0));
      item_q.push_back(cast_item(16'h3E80, 16'h0080, 0, 16384));
      drain();

      random_phase(100, 0, 0, 0);

      csr_write(gddarc_pkg::CSR_RENDER_DISTANCE, 16'hFFFF);
      csr_write(gddarc_pkg::CSR_MAP_WIDTH, 16'd64);
      csr_write(gddarc_pkg::CSR_MAP_HEIGHT, 16'd64);
      csr_write(CSR_SPARE, 16'h1234);
      random_phase(40, 60, 0, 1);

      csr_write(gddarc_pkg::CSR_RENDER_DISTANCE, 16'd1024);
      csr_write(gddarc_pkg::CSR_MAP_WIDTH, 16'd1);
      csr_write(gddarc_pkg::CSR_MAP_HEIGHT, 16'd1);
      random_phase(60, 0, 60, 0);

      csr_write(gddarc_pkg::CSR_RENDER_DISTANCE, 16'd2048);
      csr_write(gddarc_pkg::CSR_MAP_WIDTH, 16'd0);
      csr_write(gddarc_pkg::CSR_MAP_HEIGHT, 16'd127);
      random_phase(50, 38, 38, 0);

      csr_write(gddarc_pkg::CSR_RENDER_DISTANCE, 16'd0);
      csr_write(gddarc_pkg::CSR_MAP_WIDTH, 16'd37);
      csr_write(gddarc_pkg::CSR_MAP_HEIGHT, 16'd20);
      random_phase(50, 60, 0, 1);

      csr_write(gddarc_pkg::CSR_RENDER_DISTANCE, 16'(16'h0100 + $urandom_range(16'h1F00)));
      csr_write(gddarc_pkg::CSR_MAP_WIDTH, 16'd64);
      csr_write(gddarc_pkg::CSR_MAP_HEIGHT, 16'd64);
      random_phase(100, 0, 60, 0);
      random_phase(100, 38, 38, 0);

      repeat (200) @(negedge clock);
      if (errors == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end
endmodule
